// ----- rtl/name_hash_directory_lookup_top_macros.svh -----
// ----------------------------------------------------------------------------
// Name hash directory: assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef NAME_HASH_DIRECTORY_LOOKUP_TOP_MACROS_SVH
`define NAME_HASH_DIRECTORY_LOOKUP_TOP_MACROS_SVH

// Plain property, clocked, held off while in reset
`define NHD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nhd assertion failed");

// Signal holds its value in the cycle after cond
`define NHD_ASSERT_STABLE(lbl, clk, rstn, cond, sig) \
  `NHD_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig))

`endif

// ----- rtl/nhd_pkg.sv -----
// ----------------------------------------------------------------------------
// Name hash directory package
// Types, codes and byte helpers shared by the directory modules.
// ----------------------------------------------------------------------------
package nhd_pkg;

  localparam int unsigned MaxEntriesDefault = 1024;
  localparam int unsigned NameW   = 64;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HashW   = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_BUILD  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_APPENDED,
    RES_FOUND
  } res_sel_e;

  typedef enum logic [1:0] {
    IDX_KEEP,
    IDX_ZERO,
    IDX_INC
  } idx_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DONE,
    S_CLR,
    S_B_RD,
    S_B_HS,
    S_B_HASH,
    S_B_MOD,
    S_B_HEAD,
    S_B_LINK,
    S_L_HASH,
    S_L_MOD,
    S_L_HEAD,
    S_L_WALK,
    S_L_CHK,
    S_L_CMP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic     accept;
    logic     append_wr;
    logic     clr_wr;
    logic     link_wr;
    idx_op_e  idx_op;
    logic     name_rd_idx;
    logic     name_rd_cur;
    logic     head_rd;
    logic     hash_start;
    logic     hash_src_mem;
    logic     hash_step;
    logic     mod_step;
    logic     walk_start;
    logic     walk_next;
    logic     built_set;
    logic     res_set;
    res_sel_e res_sel;
    status_e  res_status;
    logic     res_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic built;
    logic idx_last;
    logic hash_last;
    logic mod_last;
    logic walk_ok;
    logic match;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] upper8(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) u = c - 8'h20;
    return u;
  endfunction

  // equal up to and including the first zero byte, or over all 8 bytes
  function automatic logic names_match(input logic [NameW-1:0] a,
                                       input logic [NameW-1:0] b);
    logic       ok;
    logic       stop;
    logic [7:0] ua;
    logic [7:0] ub;
    ok   = 1'b1;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      ua = upper8(a[8*k +: 8]);
      ub = upper8(b[8*k +: 8]);
      if (!stop) begin
        if (ua != ub) begin
          ok   = 1'b0;
          stop = 1'b1;
        end else if (ua == 8'h00) begin
          stop = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

// ----- rtl/nhd_if.sv -----
// ----------------------------------------------------------------------------
// Name hash directory channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface nhd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] name;

  modport source (output valid, op, name, input ready);
  modport sink   (input valid, op, name, output ready);
endinterface

interface nhd_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] index;
  logic [1:0]         status;
  logic [10:0]        entries;

  modport source (output valid, index, status, entries, input ready);
  modport sink   (input valid, index, status, entries, output ready);
endinterface

// ----- rtl/nhd_datapath.sv -----
// ----------------------------------------------------------------------------
// Name hash directory datapath
// Name store, chain memories, iterative hash and modulo, result register.
// ----------------------------------------------------------------------------
module nhd_datapath import nhd_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [NameW-1:0]         in_name_i,
  input  ctl_t                     ctl_i,
  output sts_t                     sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [IndexW-1:0] out_index_o,
  output logic [StatusW-1:0]       out_status_o,
  output logic [IndexW-1:0]        out_entries_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // memories
  logic [NameW-1:0] name_mem [MAX_ENTRIES];
  logic [AW:0]      head_mem [MAX_ENTRIES];
  logic [AW:0]      next_mem [MAX_ENTRIES];

  logic [NameW-1:0] name_rd_q;
  logic [AW:0]      head_rd_q;
  logic [AW:0]      next_rd_q;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             built_q, built_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [NameW-1:0] qname_q;
  logic [NameW-1:0] hname_q, hname_d;
  logic [HashW-1:0] h_q, h_d;
  logic [2:0]       hk_q, hk_d;
  logic [CW-1:0]    r_q, r_d;
  logic [4:0]       mbit_q, mbit_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic             cur_v_q, cur_v_d;
  logic [CW-1:0]    steps_q, steps_d;

  logic [IndexW-1:0] pend_idx_q;
  logic [StatusW-1:0] pend_st_q;
  logic              out_valid_q;
  logic [IndexW-1:0] out_idx_q;
  logic [StatusW-1:0] out_st_q;
  logic [IndexW-1:0] out_ent_q;

  logic [AW-1:0]    idx_a;
  logic [AW-1:0]    r_a;
  logic [7:0]       hbyte;
  logic [HashW-1:0] h_mul;
  logic [NameW-1:0] hsrc;
  logic [CW:0]      mod_t;
  logic             mod_ge;

  assign idx_a = idx_q[AW-1:0];
  assign r_a   = r_q[AW-1:0];
  assign hbyte = hname_q[{hk_q, 3'b000} +: 8];
  assign h_mul = (hk_q == 3'd1) ? (h_q + {h_q[HashW-2:0], 1'b0}) : {h_q[HashW-2:0], 1'b0};
  assign hsrc  = ctl_i.hash_src_mem ? name_rd_q : in_name_i;
  assign mod_t = {r_q, h_q[mbit_q]};
  assign mod_ge = mod_t >= {1'b0, cnt_q};

  // ---- memories ----
  always_ff @(posedge clk_i) begin
    if (ctl_i.append_wr) name_mem[cnt_q[AW-1:0]] <= in_name_i;
    if (ctl_i.name_rd_idx) name_rd_q <= name_mem[idx_a];
    else if (ctl_i.name_rd_cur) name_rd_q <= name_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_wr) head_mem[idx_a] <= '0;
    else if (ctl_i.link_wr) head_mem[r_a] <= {1'b1, idx_a};
    if (ctl_i.head_rd) head_rd_q <= head_mem[r_a];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_wr) next_mem[idx_a] <= head_rd_q;
    if (ctl_i.name_rd_cur) next_rd_q <= next_mem[cur_q];
  end

  // ---- control registers ----
  always_comb begin
    cnt_d   = cnt_q;
    built_d = built_q;
    idx_d   = idx_q;
    if (ctl_i.append_wr) begin
      cnt_d   = cnt_q + 1'b1;
      built_d = 1'b0;
    end
    if (ctl_i.built_set) built_d = 1'b1;
    case (ctl_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_INC:  idx_d = idx_q + 1'b1;
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      built_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      built_q <= built_d;
      idx_q   <= idx_d;
    end
  end

  // ---- hash, modulo and chain walk ----
  always_comb begin
    hname_d = hname_q;
    h_d     = h_q;
    hk_d    = hk_q;
    r_d     = r_q;
    mbit_d  = mbit_q;
    cur_d   = cur_q;
    cur_v_d = cur_v_q;
    steps_d = steps_q;
    if (ctl_i.hash_start) begin
      hname_d = hsrc;
      h_d     = {{(HashW-8){1'b0}}, upper8(hsrc[7:0])};
      hk_d    = 3'd1;
      r_d     = '0;
      mbit_d  = 5'd31;
    end else if (ctl_i.hash_step) begin
      // a zero byte ends the name, except the last byte which always folds in
      if (hk_q == 3'd7 || hbyte != 8'h00) begin
        h_d  = h_mul + {{(HashW-8){1'b0}}, upper8(hbyte)};
        hk_d = hk_q + 3'd1;
      end
    end
    if (ctl_i.mod_step) begin
      r_d    = mod_ge ? CW'(mod_t - {1'b0, cnt_q}) : mod_t[CW-1:0];
      mbit_d = mbit_q - 5'd1;
    end
    if (ctl_i.walk_start) begin
      cur_d   = head_rd_q[AW-1:0];
      cur_v_d = head_rd_q[AW];
      steps_d = '0;
    end else if (ctl_i.walk_next) begin
      cur_d   = next_rd_q[AW-1:0];
      cur_v_d = next_rd_q[AW];
      steps_d = steps_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) qname_q <= in_name_i;
    hname_q <= hname_d;
    h_q     <= h_d;
    hk_q    <= hk_d;
    r_q     <= r_d;
    mbit_q  <= mbit_d;
    cur_q   <= cur_d;
    steps_q <= steps_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cur_v_q <= 1'b0;
    else         cur_v_q <= cur_v_d;
  end

  // ---- result ----
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_set) begin
      pend_st_q <= ctl_i.res_status;
      case (ctl_i.res_sel)
        RES_APPENDED: pend_idx_q <= IndexW'(cnt_q);
        RES_FOUND:    pend_idx_q <= IndexW'(cur_q);
        default:      pend_idx_q <= '1;
      endcase
    end
    if (ctl_i.res_load) begin
      out_idx_q <= pend_idx_q;
      out_st_q  <= pend_st_q;
      out_ent_q <= IndexW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (ctl_i.res_load) out_valid_q <= 1'b1;
    else if (out_ready_i)    out_valid_q <= 1'b0;
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_idx_q;
  assign out_status_o  = out_st_q;
  assign out_entries_o = out_ent_q;

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.full      = (cnt_q == CW'(MAX_ENTRIES));
  assign sts_o.built     = built_q;
  assign sts_o.idx_last  = (idx_q == cnt_q - 1'b1);
  assign sts_o.hash_last = (hk_q == 3'd7) || (hbyte == 8'h00);
  assign sts_o.mod_last  = (mbit_q == 5'd0);
  assign sts_o.walk_ok   = cur_v_q && (CW'(cur_q) < cnt_q) && (steps_q < cnt_q);
  assign sts_o.match     = names_match(name_rd_q, qname_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/nhd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Name hash directory controller
// Sequences append, chain build and chain walk over the datapath.
// ----------------------------------------------------------------------------
module nhd_ctrl import nhd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(in_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            OP_BUILD:  state_d = sts_i.cnt_zero ? S_DONE : S_CLR;
            OP_LOOKUP: state_d = (!sts_i.built || sts_i.cnt_zero) ? S_DONE : S_L_HASH;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_CLR:    if (sts_i.idx_last) state_d = S_B_RD;
      S_B_RD:   state_d = S_B_HS;
      S_B_HS:   state_d = S_B_HASH;
      S_B_HASH: if (sts_i.hash_last) state_d = S_B_MOD;
      S_B_MOD:  if (sts_i.mod_last) state_d = S_B_HEAD;
      S_B_HEAD: state_d = S_B_LINK;
      S_B_LINK: state_d = sts_i.idx_last ? S_DONE : S_B_RD;
      S_L_HASH: if (sts_i.hash_last) state_d = S_L_MOD;
      S_L_MOD:  if (sts_i.mod_last) state_d = S_L_HEAD;
      S_L_HEAD: state_d = S_L_WALK;
      S_L_WALK: state_d = S_L_CHK;
      S_L_CHK:  state_d = sts_i.walk_ok ? S_L_CMP : S_DONE;
      S_L_CMP:  state_d = sts_i.match ? S_DONE : S_L_CHK;
      S_DONE:   if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o            = '0;
    ctl_o.idx_op     = IDX_KEEP;
    ctl_o.res_sel    = RES_NONE;
    ctl_o.res_status = ST_OK;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
        if (in_valid_i) begin
          unique case (op)
            OP_APPEND: begin
              ctl_o.res_set = 1'b1;
              if (sts_i.full) begin
                ctl_o.res_status = ST_FULL;
              end else begin
                ctl_o.append_wr = 1'b1;
                ctl_o.res_sel   = RES_APPENDED;
              end
            end
            OP_BUILD: begin
              if (sts_i.cnt_zero) begin
                ctl_o.built_set = 1'b1;
                ctl_o.res_set   = 1'b1;
              end else begin
                ctl_o.idx_op = IDX_ZERO;
              end
            end
            OP_LOOKUP: begin
              if (!sts_i.built) begin
                ctl_o.res_set    = 1'b1;
                ctl_o.res_status = ST_NOT_BUILT;
              end else if (sts_i.cnt_zero) begin
                ctl_o.res_set    = 1'b1;
                ctl_o.res_status = ST_NOT_FOUND;
              end else begin
                ctl_o.hash_start = 1'b1;
              end
            end
            default: ctl_o.res_set = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        ctl_o.clr_wr = 1'b1;
        ctl_o.idx_op = sts_i.idx_last ? IDX_ZERO : IDX_INC;
      end
      S_B_RD: ctl_o.name_rd_idx = 1'b1;
      S_B_HS: begin
        ctl_o.hash_start   = 1'b1;
        ctl_o.hash_src_mem = 1'b1;
      end
      S_B_HASH, S_L_HASH: ctl_o.hash_step = 1'b1;
      S_B_MOD, S_L_MOD:   ctl_o.mod_step  = 1'b1;
      S_B_HEAD, S_L_HEAD: ctl_o.head_rd   = 1'b1;
      S_B_LINK: begin
        ctl_o.link_wr = 1'b1;
        if (sts_i.idx_last) begin
          ctl_o.built_set = 1'b1;
          ctl_o.res_set   = 1'b1;
        end else begin
          ctl_o.idx_op = IDX_INC;
        end
      end
      S_L_WALK: ctl_o.walk_start = 1'b1;
      S_L_CHK: begin
        if (sts_i.walk_ok) begin
          ctl_o.name_rd_cur = 1'b1;
        end else begin
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = ST_NOT_FOUND;
        end
      end
      S_L_CMP: begin
        if (sts_i.match) begin
          ctl_o.res_set = 1'b1;
          ctl_o.res_sel = RES_FOUND;
        end else begin
          ctl_o.walk_next = 1'b1;
        end
      end
      S_DONE: ctl_o.res_load = sts_i.out_free;
      default: ctl_o.res_load = 1'b0;
    endcase
  end

endmodule

// ----- rtl/name_hash_directory_lookup_top.sv -----
// ----------------------------------------------------------------------------
// Name hash directory lookup
// Directory of 8-byte names, chained hash build and case-insensitive lookup.
//
//   channel  dir  payload                      transaction
//   in_i     in   op[1:0], name[63:0]          valid & ready
//   out_o    out  index[10:0], status, entries valid & ready
//
// One item at a time; the result waits in an output register while the
// next item is taken. Lookup hashes the name byte-serially (up to 7 steps),
// reduces it by a bit-serial modulo (32 steps) and then walks the chain,
// probing one entry at a time. Build over n entries clears n heads, then
// hashes and links each entry in turn. No clearing pass after reset.
// ----------------------------------------------------------------------------
module name_hash_directory_lookup_top import nhd_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  nhd_in_if.sink    in_i,
  nhd_out_if.source out_o
);

  ctl_t ctl;
  sts_t sts;

  nhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  nhd_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_name_i     (in_i.name),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_index_o   (out_o.index),
    .out_status_o  (out_o.status),
    .out_entries_o (out_o.entries)
  );

endmodule

// ----- rtl/nhd_checker.sv -----
// ----------------------------------------------------------------------------
// Name hash directory checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "name_hash_directory_lookup_top_macros.svh"

module nhd_checker import nhd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [10:0] out_index_i,
  input logic [1:0]  out_status_i,
  input logic [10:0] out_entries_i
);

  // one transaction in flight: ready drops after each accept
  `NHD_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)
  // every non-ok answer carries index -1
  `NHD_ASSERT(a_err_index, clk_i, rst_ni, (out_valid_i && out_status_i != ST_OK) |-> (out_index_i == 11'h7ff))
  // results load only from the done state, where input is held off
  `NHD_ASSERT(a_load_quiet, clk_i, rst_ni, $rose(out_valid_i) |-> !$past(in_ready_i))
  `NHD_ASSERT_STABLE(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, {out_valid_i, out_index_i, out_status_i, out_entries_i})

endmodule

bind name_hash_directory_lookup_top nhd_checker u_nhd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_index_i   (out_o.index),
  .out_status_i  (out_o.status),
  .out_entries_i (out_o.entries)
);
